FILE: rtl/core/plucked_string_synth_core_macros.svh
// Assertion macros shared by the plucked string synth RTL.
`ifndef PLUCKED_STRING_SYNTH_CORE_MACROS_SVH
`define PLUCKED_STRING_SYNTH_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PSS_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PSS_ASSERT(label, clk, rst, ante, cons, msg)
`define PSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/pss_pkg.sv
// Shared constants, codes and types of the plucked string synth core.
package pss_pkg;

   localparam int MAX_LEN    = 1024;
   localparam int ADDR_W     = $clog2(MAX_LEN);
   localparam int CNT_W      = $clog2(MAX_LEN + 1);
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int TICK_W     = 32;
   localparam int LEN_W      = 11;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int MIN_LEN    = 2;

   localparam logic [LEN_W-1:0]  RING_LENGTH_RESET = LEN_W'(100);
   localparam logic [GAIN_W-1:0] DECAY_GAIN_RESET  = GAIN_W'(65274);

   // item kinds
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RING_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_GAIN  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_TICK_REJECT = 2'd1,
      STATUS_LOAD_REJECT = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] front_sample;
      logic [TICK_W-1:0]          tick_total;
      logic [CNT_W-1:0]           fill_level;
      status_type                 status;
   } rsp_payload_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] data;
   } ring_wr_type;

endpackage

FILE: rtl/core/pss_channels.sv
// Handshake channel interfaces for request, response and register write.
interface pss_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic signed [pss_pkg::SAMPLE_W-1:0] sample_value;
   logic                                first_of_pluck;

   modport source (output valid, output kind, output sample_value, output first_of_pluck,
                   input ready);
   modport sink (input valid, input kind, input sample_value, input first_of_pluck,
                 output ready);
endinterface

interface pss_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [pss_pkg::SAMPLE_W-1:0] front_sample;
   logic [pss_pkg::TICK_W-1:0]          tick_total;
   logic [pss_pkg::CNT_W-1:0]           fill_level;
   logic [pss_pkg::STATUS_W-1:0]        status;

   modport source (output valid, output front_sample, output tick_total, output fill_level,
                   output status, input ready);
   modport sink (input valid, input front_sample, input tick_total, input fill_level,
                 input status, output ready);
endinterface

interface pss_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pss_pkg::CSR_IDX_W-1:0]     index;
   logic [pss_pkg::CSR_DATA_W-1:0]    wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/core/pss_ring_mem.sv
// Sample ring memory: one write port, one registered read port with write bypass.
module pss_ring_mem (
   input  logic                             clock,
   input  pss_pkg::ring_wr_type             wr,
   input  logic [pss_pkg::ADDR_W-1:0]       rd_addr,
   output logic [pss_pkg::SAMPLE_W-1:0]     rd_data
);

   logic [pss_pkg::SAMPLE_W-1:0] mem [pss_pkg::MAX_LEN];
   logic [pss_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic [pss_pkg::SAMPLE_W-1:0] byp_data_ff;
   logic                         byp_hit_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   // same-cycle write to the read address wins over the stale array word
   always_ff @(posedge clock) begin
      byp_hit_ff  <= wr.en && (wr.addr == rd_addr);
      byp_data_ff <= wr.data;
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : rd_data_ff;

endmodule

FILE: rtl/core/pss_decay.sv
// Decay filter: average of two samples scaled by a Q0.16 gain, truncated toward zero.
module pss_decay (
   input  logic signed [pss_pkg::SAMPLE_W-1:0] a,
   input  logic signed [pss_pkg::SAMPLE_W-1:0] b,
   input  logic [pss_pkg::GAIN_W-1:0]          gain,
   output logic signed [pss_pkg::SAMPLE_W-1:0] result
);

   localparam int SUM_W  = pss_pkg::SAMPLE_W + 1;
   localparam int PROD_W = SUM_W + pss_pkg::GAIN_W;

   logic signed [SUM_W-1:0]        sum;
   logic                           neg;
   logic [SUM_W-1:0]               mag;
   logic [PROD_W-1:0]              prod;
   logic [pss_pkg::SAMPLE_W-1:0]   quot;

   always_comb begin
      sum  = SUM_W'(a) + SUM_W'(b);
      neg  = sum[SUM_W-1];
      mag  = neg ? SUM_W'(-sum) : SUM_W'(sum);
      prod = PROD_W'(mag) * PROD_W'(gain);
      // drop the halving bit and the gain's fraction bits together
      quot = prod[PROD_W-1 -: pss_pkg::SAMPLE_W];
      result = neg ? $signed(-quot) : $signed(quot);
   end

endmodule

FILE: rtl/core/pss_out_queue.sv
// Two-entry response queue that drives the response channel.
module pss_out_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pss_pkg::rsp_payload_type push_data,
   output logic                     has_room,
   pss_rsp_if.source                rsp
);

   logic [1:0]               cnt_ff;
   logic [1:0]               cnt_in;
   pss_pkg::rsp_payload_type head_ff;
   pss_pkg::rsp_payload_type head_in;
   pss_pkg::rsp_payload_type tail_ff;
   pss_pkg::rsp_payload_type tail_in;
   logic                     pop;

   assign pop      = rsp.valid && rsp.ready;
   assign has_room = (cnt_ff != 2'd2);

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      case ({push, pop})
         2'b10: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               tail_in = push_data;
            end
         end
         2'b01: begin
            cnt_in  = cnt_ff - 2'd1;
            head_in = tail_ff;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = tail_ff;
               tail_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp.valid        = (cnt_ff != 2'd0);
   assign rsp.front_sample = head_ff.front_sample;
   assign rsp.tick_total   = head_ff.tick_total;
   assign rsp.fill_level   = head_ff.fill_level;
   assign rsp.status       = head_ff.status;

endmodule

FILE: rtl/core/plucked_string_synth_core.sv
// A request is held in the input register and its result in the response queue.
// Throughput: one item per cycle while that queue has room; the ring memory does
// one write and one read a cycle, and the two front samples live in registers.
// Reset: clears fill level, front index and tick count, and loads ring_length
// 100 and decay_gain 65274; ring contents are not cleared and there is no
// clearing pass, so items are taken right after reset.
`include "plucked_string_synth_core_macros.svh"

module plucked_string_synth_core (
   input  logic      clock,
   input  logic      reset,
   pss_req_if.sink   req_chan,
   pss_rsp_if.source rsp_chan,
   pss_csr_if.sink   csr_chan
);

   localparam int ADDR_W   = pss_pkg::ADDR_W;
   localparam int CNT_W    = pss_pkg::CNT_W;
   localparam int SAMPLE_W = pss_pkg::SAMPLE_W;
   localparam int TICK_W   = pss_pkg::TICK_W;

   // input register
   logic                       in_valid_ff;
   logic                       in_valid_in;
   logic                       in_kind_ff;
   logic signed [SAMPLE_W-1:0] in_sample_ff;
   logic                       in_first_ff;

   // ring control state
   logic [ADDR_W-1:0]          front_idx_ff;
   logic [ADDR_W-1:0]          front_idx_in;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic [TICK_W-1:0]          tick_ff;
   logic [TICK_W-1:0]          tick_in;
   logic signed [SAMPLE_W-1:0] front_ff;
   logic signed [SAMPLE_W-1:0] front_in;
   logic signed [SAMPLE_W-1:0] second_ff;
   logic signed [SAMPLE_W-1:0] second_in;

   // configuration
   logic [pss_pkg::LEN_W-1:0]  ring_length_ff;
   logic [pss_pkg::GAIN_W-1:0] decay_gain_ff;

   logic                       accept;
   logic                       fire;
   logic                       q_room;
   logic [CNT_W-1:0]           cap;
   logic [SAMPLE_W-1:0]        third;
   logic signed [SAMPLE_W-1:0] decayed;
   logic [ADDR_W-1:0]          rd_addr;
   pss_pkg::ring_wr_type       wr;
   pss_pkg::status_type        status;
   pss_pkg::rsp_payload_type   rsp_data;

   assign req_chan.ready = !in_valid_ff || q_room;
   assign accept         = req_chan.valid && req_chan.ready;
   assign fire           = in_valid_ff && q_room;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_kind_ff   <= req_chan.kind;
         in_sample_ff <= req_chan.sample_value;
         in_first_ff  <= req_chan.first_of_pluck;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_length_ff <= pss_pkg::RING_LENGTH_RESET;
         decay_gain_ff  <= pss_pkg::DECAY_GAIN_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            pss_pkg::CSR_RING_LENGTH: ring_length_ff <= csr_chan.wdata[pss_pkg::LEN_W-1:0];
            pss_pkg::CSR_DECAY_GAIN:  decay_gain_ff  <= csr_chan.wdata[pss_pkg::GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // clamp the programmed length to the supported range
   always_comb begin
      if (CNT_W'(ring_length_ff) < CNT_W'(pss_pkg::MIN_LEN)) begin
         cap = CNT_W'(pss_pkg::MIN_LEN);
      end else if (CNT_W'(ring_length_ff) > CNT_W'(pss_pkg::MAX_LEN)) begin
         cap = CNT_W'(pss_pkg::MAX_LEN);
      end else begin
         cap = CNT_W'(ring_length_ff);
      end
   end

   pss_decay u_decay (
      .a      (front_ff),
      .b      (second_ff),
      .gain   (decay_gain_ff),
      .result (decayed)
   );

   always_comb begin
      front_idx_in = front_idx_ff;
      count_in     = count_ff;
      tick_in      = tick_ff;
      front_in     = front_ff;
      second_in    = second_ff;
      status       = pss_pkg::STATUS_OK;
      wr.en        = 1'b0;
      wr.addr      = front_idx_ff + count_ff[ADDR_W-1:0];
      wr.data      = in_sample_ff;
      if (fire) begin
         if (in_kind_ff == pss_pkg::KIND_LOAD) begin
            if (in_first_ff) begin
               // start of a pluck: empty the ring, then enqueue
               front_idx_in = '0;
               count_in     = CNT_W'(1);
               front_in     = in_sample_ff;
               wr.en        = 1'b1;
               wr.addr      = '0;
            end else if (count_ff >= cap) begin
               status = pss_pkg::STATUS_LOAD_REJECT;
            end else begin
               wr.en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (count_ff == CNT_W'(0)) begin
                  front_in = in_sample_ff;
               end
               if (count_ff == CNT_W'(1)) begin
                  second_in = in_sample_ff;
               end
            end
         end else begin
            if (count_ff < CNT_W'(2)) begin
               status = pss_pkg::STATUS_TICK_REJECT;
            end else begin
               // drop the front, enqueue the decayed average behind the rest
               front_idx_in = front_idx_ff + ADDR_W'(1);
               tick_in      = tick_ff + TICK_W'(1);
               front_in     = second_ff;
               second_in    = (count_ff == CNT_W'(2)) ? decayed : $signed(third);
               wr.en        = 1'b1;
               wr.data      = decayed;
            end
         end
      end
      rd_addr               = front_idx_in + ADDR_W'(2);
      rsp_data.front_sample = (count_in != CNT_W'(0)) ? front_in : '0;
      rsp_data.tick_total   = tick_in;
      rsp_data.fill_level   = count_in;
      rsp_data.status       = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_idx_ff <= '0;
         count_ff     <= '0;
         tick_ff      <= '0;
      end else begin
         front_idx_ff <= front_idx_in;
         count_ff     <= count_in;
         tick_ff      <= tick_in;
      end
      front_ff  <= front_in;
      second_ff <= second_in;
   end

   pss_ring_mem u_ring_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (third)
   );

   pss_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_data (rsp_data),
      .has_room  (q_room),
      .rsp       (rsp_chan)
   );

   `PSS_ASSERT(fill_bounded_a, clock, reset, 1'b1, count_ff <= CNT_W'(pss_pkg::MAX_LEN), "fill level above ring size")
   `PSS_ASSERT_NEXT(reject_holds_fill_a, clock, reset, fire && (status != pss_pkg::STATUS_OK), $stable(count_ff) && $stable(front_idx_ff), "rejected item changed the ring")
   `PSS_ASSERT_NEXT(tick_counts_a, clock, reset, fire && (in_kind_ff == pss_pkg::KIND_TICK) && (status == pss_pkg::STATUS_OK), tick_ff == $past(tick_ff) + TICK_W'(1), "accepted tick not counted")
   `PSS_ASSERT(stall_only_when_held_a, clock, reset, !req_chan.ready, in_valid_ff && !q_room, "request stalled with room to spare")

endmodule
